### rtl/lcp_pkg.sv
// Shared types and constants of the complementarity residual checker.
package lcp_pkg;

	// Default for the largest problem dimension the stores can hold.
	localparam int MAX_SIZE_DEF = 64;

	// Fixed widths of the item fields and registers.
	localparam int VAL_W  = 32;
	localparam int ERR_W  = 64;
	localparam int SIZE_W = 7;
	localparam int TOL_W  = 32;
	localparam int CFG_W  = 32;

	// Register reset values.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
	localparam logic [TOL_W-1:0]  TOL_RESET  = 32'd16777;

	// Configuration register indexes.
	localparam logic CFG_SIZE = 1'b0;
	localparam logic CFG_TOL  = 1'b1;

	// Saturation limits of a Q16.16 value.
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	// Item operation codes.
	typedef enum logic [1:0] {
		OP_LOAD_M = 2'd0,
		OP_LOAD_Q = 2'd1,
		OP_LOAD_Z = 2'd2,
		OP_EVAL   = 2'd3
	} op_t;

	// Write enables of the three stores.
	typedef struct packed {
		logic m;
		logic q;
		logic z;
	} wr_sel_t;

endpackage

### rtl/lcp_residual_check.sv
// Top level of the linear complementarity residual checker.
//
// Items enter on a command port: an item is taken at a rising edge with
// start high and busy low. Load items write one entry of the matrix M or of
// the vectors q and z (signed Q16.16) into synchronous memories and leave
// busy low, so loads stream in at one item per cycle while no evaluate is
// running. An evaluate item raises busy and sweeps all n*n matrix entries,
// one memory read per cycle, where n is size_in_use clamped to MAX_SIZE. The
// sweep feeds a multiply-accumulate and a short per-row pipeline that forms
// w, the error terms and the sum of q squared; a shared 32x32 multiplier
// then works through eleven partial products for the final norm test.
// The result (failed, error_sum) is shown for exactly one cycle with done
// high once the comparison is through. busy falls in the done cycle, so the
// next item can be taken there. The receiver cannot hold a result off.
// Configuration writes go through cfg_valid/cfg_ready and are meant for idle
// periods. Reset clears the control state and sets size_in_use to 64 and
// tolerance to 16777; the stores are not cleared and every entry used by an
// evaluate must be loaded first.
module lcp_residual_check import lcp_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              operation,
	input  logic [5:0]              row,
	input  logic [5:0]              column,
	input  logic signed [VAL_W-1:0] value,
	output logic                    done,
	output logic                    failed,
	output logic [ERR_W-1:0]        error_sum,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int IW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int CW  = $clog2(MAX_SIZE + 1);
	localparam int MAW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;
	localparam int SQW = 63 + $clog2(MAX_SIZE);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_CMP
	} state_t;

	state_t            state_q;
	logic              done_q;
	logic              failed_q;
	logic [ERR_W-1:0]  err_out_q;

	logic [SIZE_W-1:0] size_q;
	logic [TOL_W-1:0]  tol_q;
	logic [CW-1:0]     n_eff;

	logic              take;
	logic              take_eval;
	logic              take_load;
	logic              in_range;
	op_t               op;
	wr_sel_t           wsel;
	logic [MAW-1:0]    m_waddr;
	logic [IW-1:0]     v_waddr;

	logic [MAW-1:0]          m_raddr;
	logic [IW-1:0]           zj_raddr;
	logic [IW-1:0]           row_raddr;
	logic signed [VAL_W-1:0] m_rd, zj_rd, zi_rd, q_rd;

	logic              sweep_done;
	logic [ERR_W-1:0]  sweep_err;
	logic [SQW-1:0]    sweep_sq;
	logic              cmp_start;
	logic              cmp_done;
	logic              cmp_fail;

	// The stores are never written while an evaluate runs: busy blocks loads,
	// so the sweep reads need no forwarding.
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign op        = op_t'(operation);
	assign take      = start && !busy;
	assign take_eval = take && (op == OP_EVAL);
	assign take_load = take && (op != OP_EVAL);

	// Loads outside the stores are dropped; the column only matters for M.
	assign in_range = (int'(row) < MAX_SIZE) &&
		((op != OP_LOAD_M) || (int'(column) < MAX_SIZE));

	always_comb begin
		wsel.m  = take_load && in_range && (op == OP_LOAD_M);
		wsel.q  = take_load && in_range && (op == OP_LOAD_Q);
		wsel.z  = take_load && in_range && (op == OP_LOAD_Z);
		m_waddr = MAW'(MAW'(row) * MAW'(MAX_SIZE) + MAW'(column));
		v_waddr = IW'(row);
	end

	// Dimensions above the store size are clamped.
	assign n_eff = (int'(size_q) > MAX_SIZE) ? CW'(MAX_SIZE) : CW'(size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			tol_q  <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SIZE: size_q <= cfg_data[SIZE_W-1:0];
				CFG_TOL:  tol_q  <= cfg_data[TOL_W-1:0];
				default:  tol_q  <= tol_q;
			endcase
		end
	end

	// The comparison starts as soon as the sweep has flushed its pipeline.
	assign cmp_start = (state_q == ST_SWEEP) && sweep_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			failed_q  <= 1'b0;
			err_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take_eval) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (sweep_done) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (cmp_done) begin
						state_q   <= ST_IDLE;
						done_q    <= 1'b1;
						failed_q  <= cmp_fail;
						err_out_q <= sweep_err;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign failed    = failed_q;
	assign error_sum = err_out_q;

	lcp_store #(
		.MAX_SIZE (MAX_SIZE)
	) u_store (
		.clk       (clk),
		.wsel      (wsel),
		.m_waddr   (m_waddr),
		.v_waddr   (v_waddr),
		.wdata     (value),
		.m_raddr   (m_raddr),
		.zj_raddr  (zj_raddr),
		.row_raddr (row_raddr),
		.m_rd      (m_rd),
		.zj_rd     (zj_rd),
		.zi_rd     (zi_rd),
		.q_rd      (q_rd)
	);

	lcp_sweep #(
		.MAX_SIZE (MAX_SIZE)
	) u_sweep (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (take_eval),
		.n_eff    (n_eff),
		.m_addr   (m_raddr),
		.zj_addr  (zj_raddr),
		.row_addr (row_raddr),
		.m_rd     (m_rd),
		.zj_rd    (zj_rd),
		.zi_rd    (zi_rd),
		.q_rd     (q_rd),
		.done     (sweep_done),
		.err_sum  (sweep_err),
		.sum_sq   (sweep_sq)
	);

	lcp_norm_cmp #(
		.MAX_SIZE (MAX_SIZE)
	) u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmp_start),
		.err    (sweep_err),
		.sum_sq (sweep_sq),
		.tol    (tol_q),
		.done   (cmp_done),
		.fail   (cmp_fail)
	);

	// A result is only shown once the block is free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// A taken evaluate always occupies the block in the following cycle.
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take_eval |=> busy)
		else $error("evaluate did not raise busy");

	// A result strobe follows the comparison phase directly.
	a_done_after_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_CMP))
		else $error("result without comparison");

	// The sweep finishes only while it is expected to.
	a_sweep_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_done |-> (state_q == ST_SWEEP))
		else $error("sweep finished outside the sweep phase");

endmodule

### rtl/lcp_store.sv
// Matrix, q and z stores with synchronous write and registered reads.
module lcp_store import lcp_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF,
	localparam int IW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
	localparam int MAW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1
) (
	input  logic                    clk,
	input  wr_sel_t                 wsel,
	input  logic [MAW-1:0]          m_waddr,
	input  logic [IW-1:0]           v_waddr,
	input  logic signed [VAL_W-1:0] wdata,
	input  logic [MAW-1:0]          m_raddr,
	input  logic [IW-1:0]           zj_raddr,
	input  logic [IW-1:0]           row_raddr,
	output logic signed [VAL_W-1:0] m_rd,
	output logic signed [VAL_W-1:0] zj_rd,
	output logic signed [VAL_W-1:0] zi_rd,
	output logic signed [VAL_W-1:0] q_rd
);

	logic signed [VAL_W-1:0] m_mem [MAX_SIZE*MAX_SIZE];
	logic signed [VAL_W-1:0] q_mem [MAX_SIZE];
	logic signed [VAL_W-1:0] z_mem [MAX_SIZE];

	logic signed [VAL_W-1:0] m_rd_q;
	logic signed [VAL_W-1:0] zj_rd_q;
	logic signed [VAL_W-1:0] zi_rd_q;
	logic signed [VAL_W-1:0] q_rd_q;

	always_ff @(posedge clk) begin
		if (wsel.m) begin
			m_mem[m_waddr] <= wdata;
		end
		m_rd_q <= m_mem[m_raddr];
	end

	always_ff @(posedge clk) begin
		if (wsel.q) begin
			q_mem[v_waddr] <= wdata;
		end
		q_rd_q <= q_mem[row_raddr];
	end

	// The z store has one write port and two read ports.
	always_ff @(posedge clk) begin
		if (wsel.z) begin
			z_mem[v_waddr] <= wdata;
		end
		zj_rd_q <= z_mem[zj_raddr];
		zi_rd_q <= z_mem[row_raddr];
	end

	assign m_rd  = m_rd_q;
	assign zj_rd = zj_rd_q;
	assign zi_rd = zi_rd_q;
	assign q_rd  = q_rd_q;

endmodule

### rtl/lcp_sweep.sv
// Row sweep: address sequencer, multiply-accumulate and per-row error pipeline.
module lcp_sweep import lcp_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF,
	localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
	localparam int CW    = $clog2(MAX_SIZE + 1),
	localparam int MAW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1,
	localparam int ACC_W = 64 + $clog2(MAX_SIZE),
	localparam int SQW   = 63 + $clog2(MAX_SIZE)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [CW-1:0]           n_eff,
	output logic [MAW-1:0]          m_addr,
	output logic [IW-1:0]           zj_addr,
	output logic [IW-1:0]           row_addr,
	input  logic signed [VAL_W-1:0] m_rd,
	input  logic signed [VAL_W-1:0] zj_rd,
	input  logic signed [VAL_W-1:0] zi_rd,
	input  logic signed [VAL_W-1:0] q_rd,
	output logic                    done,
	output logic [ERR_W-1:0]        err_sum,
	output logic [SQW-1:0]          sum_sq
);

	localparam int HW = ACC_W - 16;

	// Sequencer.
	logic           run_q;
	logic [IW-1:0]  i_q;
	logic [IW-1:0]  j_q;
	logic [MAW-1:0] base_q;
	logic           last_j;
	logic           last_i;

	// Pipeline flags.
	logic v_s1, first_s1, last_s1, fin_s1;
	logic v_s2, first_s2, last_s2, fin_s2;
	logic v_s3, fin_s3;
	logic v_s4, fin_s4;
	logic v_s5, fin_s5;
	logic v_s6, fin_s6;
	logic done_q;

	// Pipeline payload.
	logic signed [63:0]       prod_s2;
	logic signed [VAL_W-1:0]  q_s2, zi_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_next;
	logic signed [ACC_W-1:0]  row_s3;
	logic signed [VAL_W-1:0]  q_s3, zi_s3;
	logic signed [HW:0]       wsum;
	logic [HW-31:0]           whi;
	logic signed [VAL_W-1:0]  w_sat;
	logic signed [VAL_W-1:0]  w_s4, q_s4, zi_s4;
	logic [32:0]              negz, negw;
	logic signed [63:0]       zw_s5, qq_s5;
	logic                     same_s5;
	logic [47:0]              nz_s5, nw_s5;
	logic [ERR_W-1:0]         term_s6;
	logic [ERR_W:0]           err_add;
	logic [ERR_W-1:0]         err_q;
	logic [SQW-1:0]           sumsq_q;

	assign last_j   = (CW'(j_q) == CW'(n_eff - CW'(1)));
	assign last_i   = (CW'(i_q) == CW'(n_eff - CW'(1)));
	assign m_addr   = MAW'(base_q + MAW'(j_q));
	assign zj_addr  = j_q;
	assign row_addr = i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
			base_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				run_q  <= (n_eff != '0);
				i_q    <= '0;
				j_q    <= '0;
				base_q <= '0;
			end else if (run_q) begin
				if (last_j) begin
					j_q    <= '0;
					i_q    <= i_q + IW'(1);
					base_q <= MAW'(base_q + MAW'(MAX_SIZE));
					if (last_i) begin
						run_q <= 1'b0;
					end
				end else begin
					j_q <= j_q + IW'(1);
				end
			end
			v_s1   <= run_q;
			v_s2   <= v_s1;
			v_s3   <= v_s2 && last_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			done_q <= (start && (n_eff == '0)) || (v_s6 && fin_s6);
		end
	end

	// Row sum of M*z, w = floor(sum / 2^16) + q saturated.
	always_comb begin
		acc_next = (first_s2 ? '0 : acc_q) + ACC_W'(prod_s2);
		wsum     = (HW+1)'($signed(row_s3[ACC_W-1:16])) + (HW+1)'(q_s3);
		whi      = wsum[HW:31];
		if ((&whi) || !(|whi)) begin
			w_sat = wsum[31:0];
		end else begin
			w_sat = wsum[HW] ? VAL_MIN : VAL_MAX;
		end
		negz    = 33'd0 - {zi_s4[31], zi_s4};
		negw    = 33'd0 - {w_s4[31], w_s4};
		err_add = {1'b0, err_q} + {1'b0, term_s6};
	end

	always_ff @(posedge clk) begin
		first_s1 <= (j_q == '0);
		last_s1  <= last_j;
		fin_s1   <= last_j && last_i;

		prod_s2  <= m_rd * zj_rd;
		q_s2     <= q_rd;
		zi_s2    <= zi_rd;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		fin_s2   <= fin_s1;

		if (v_s2) begin
			acc_q <= acc_next;
		end
		row_s3 <= acc_next;
		q_s3   <= q_s2;
		zi_s3  <= zi_s2;
		fin_s3 <= fin_s2;

		w_s4   <= w_sat;
		q_s4   <= q_s3;
		zi_s4  <= zi_s3;
		fin_s4 <= fin_s3;

		zw_s5   <= zi_s4 * w_s4;
		qq_s5   <= q_s4 * q_s4;
		same_s5 <= (zi_s4[31] && w_s4[31]) ||
			(!zi_s4[31] && (|zi_s4) && !w_s4[31] && (|w_s4));
		nz_s5   <= zi_s4[31] ? {negz[31:0], 16'h0000} : 48'd0;
		nw_s5   <= w_s4[31] ? {negw[31:0], 16'h0000} : 48'd0;
		fin_s5  <= fin_s4;

		term_s6 <= 64'(nz_s5) + 64'(nw_s5) + (same_s5 ? $unsigned(zw_s5) : 64'd0);
		fin_s6  <= fin_s5;

		if (start) begin
			sumsq_q <= '0;
		end else if (v_s5) begin
			sumsq_q <= SQW'(sumsq_q + SQW'($unsigned(qq_s5)));
		end

		if (start) begin
			err_q <= '0;
		end else if (v_s6) begin
			err_q <= err_add[ERR_W] ? '1 : err_add[ERR_W-1:0];
		end
	end

	assign done    = done_q;
	assign err_sum = err_q;
	assign sum_sq  = sumsq_q;

endmodule

### rtl/lcp_norm_cmp.sv
// Sequential comparison of err^2 * 2^16 against tolerance^2 * sum(q^2).
module lcp_norm_cmp import lcp_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF,
	localparam int SQW = 63 + $clog2(MAX_SIZE)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ERR_W-1:0] err,
	input  logic [SQW-1:0]   sum_sq,
	input  logic [TOL_W-1:0] tol,
	output logic             done,
	output logic             fail
);

	typedef enum logic [1:0] {
		TGT_T,
		TGT_A,
		TGT_B
	} tgt_t;

	localparam logic [3:0] LAST_STEP = 4'd10;

	logic         run_q;
	logic [3:0]   step_q;
	logic [31:0]  op_a, op_b;
	logic [1:0]   sh;
	tgt_t         tgt;
	logic [95:0]  s_ext;

	logic         pv_q, plast_q, fin_q, done_q, fail_q;
	logic [63:0]  prod_q;
	logic [1:0]   sh_q;
	tgt_t         tgt_q;
	logic [63:0]  tol2_q;
	logic [127:0] acc_a_q;
	logic [159:0] acc_b_q;

	assign s_ext = 96'(sum_sq);

	// Partial products: tol*tol first, then err*err, then tol2*S by 32-bit digits.
	always_comb begin
		op_a = tol;
		op_b = tol;
		sh   = 2'd0;
		tgt  = TGT_T;
		case (step_q)
			4'd0: begin
				op_a = tol;            op_b = tol;            sh = 2'd0; tgt = TGT_T;
			end
			4'd1: begin
				op_a = err[31:0];      op_b = err[31:0];      sh = 2'd0; tgt = TGT_A;
			end
			4'd2: begin
				op_a = err[31:0];      op_b = err[63:32];     sh = 2'd1; tgt = TGT_A;
			end
			4'd3: begin
				op_a = err[63:32];     op_b = err[31:0];      sh = 2'd1; tgt = TGT_A;
			end
			4'd4: begin
				op_a = err[63:32];     op_b = err[63:32];     sh = 2'd2; tgt = TGT_A;
			end
			4'd5: begin
				op_a = tol2_q[31:0];   op_b = s_ext[31:0];    sh = 2'd0; tgt = TGT_B;
			end
			4'd6: begin
				op_a = tol2_q[31:0];   op_b = s_ext[63:32];   sh = 2'd1; tgt = TGT_B;
			end
			4'd7: begin
				op_a = tol2_q[31:0];   op_b = s_ext[95:64];   sh = 2'd2; tgt = TGT_B;
			end
			4'd8: begin
				op_a = tol2_q[63:32];  op_b = s_ext[31:0];    sh = 2'd1; tgt = TGT_B;
			end
			4'd9: begin
				op_a = tol2_q[63:32];  op_b = s_ext[63:32];   sh = 2'd2; tgt = TGT_B;
			end
			4'd10: begin
				op_a = tol2_q[63:32];  op_b = s_ext[95:64];   sh = 2'd3; tgt = TGT_B;
			end
			default: begin
				op_a = tol;            op_b = tol;            sh = 2'd0; tgt = TGT_T;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			step_q  <= '0;
			pv_q    <= 1'b0;
			plast_q <= 1'b0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == LAST_STEP) begin
					run_q <= 1'b0;
				end
			end
			pv_q    <= run_q && !start;
			plast_q <= run_q && (step_q == LAST_STEP);
			fin_q   <= pv_q && plast_q;
			done_q  <= fin_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		sh_q   <= sh;
		tgt_q  <= tgt;
		if (start) begin
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else if (pv_q) begin
			case (tgt_q)
				TGT_T: tol2_q <= prod_q;
				TGT_A: acc_a_q <= acc_a_q + (128'(prod_q) << {sh_q, 5'd0});
				TGT_B: acc_b_q <= acc_b_q + (160'(prod_q) << {sh_q, 5'd0});
				default: tol2_q <= prod_q;
			endcase
		end
		if (fin_q) begin
			fail_q <= ({16'd0, acc_a_q, 16'd0} > acc_b_q);
		end
	end

	assign done = done_q;
	assign fail = fail_q;

endmodule

### verif/lcp_residual_check_monitor.sv
// Monitor that predicts each residual check result and compares it with the block output.
module lcp_residual_check_monitor import lcp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [1:0]              operation,
	input  logic [5:0]              row,
	input  logic [5:0]              column,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    done,
	input  logic                    failed,
	input  logic [ERR_W-1:0]        error_sum,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output int                      mismatch_count,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic             failed;
		logic [ERR_W-1:0] error_sum;
	} verdict_t;

	// Shadow copies of the three stores and the two registers.
	logic signed [VAL_W-1:0] m_shadow [MAX_SIZE_DEF*MAX_SIZE_DEF];
	logic signed [VAL_W-1:0] q_shadow [MAX_SIZE_DEF];
	logic signed [VAL_W-1:0] z_shadow [MAX_SIZE_DEF];
	logic [SIZE_W-1:0]       size_shadow;
	logic [TOL_W-1:0]        tol_shadow;

	verdict_t awaited_verdicts[$];
	int       bad_count;

	function automatic logic [ERR_W-1:0] sat_add(logic [ERR_W-1:0] a, logic [ERR_W-1:0] b);
		logic [ERR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ERR_W] ? '1 : s[ERR_W-1:0];
	endfunction

	// Computes w = q + M z over the active dimension, the saturating error sum and
	// the squared norm test, all in exact wide arithmetic.
	function automatic verdict_t residual_verdict();
		int                 dim;
		logic signed [79:0] mz_sum;
		logic signed [79:0] w_wide;
		logic signed [63:0] w_i;
		logic signed [63:0] z_i;
		logic signed [63:0] q_i;
		logic signed [63:0] zw;
		logic [63:0]        mag;
		logic [63:0]        q_sq;
		logic [ERR_W-1:0]   err;
		logic [127:0]       q_sq_sum;
		logic [191:0]       lhs;
		logic [191:0]       rhs;
		logic [191:0]       tol_sq;
		verdict_t           v;
		dim = (size_shadow > MAX_SIZE_DEF) ? MAX_SIZE_DEF : int'(size_shadow);
		err = '0;
		q_sq_sum = '0;
		for (int i = 0; i < dim; i++) begin
			mz_sum = '0;
			for (int j = 0; j < dim; j++)
				mz_sum = mz_sum + m_shadow[i*MAX_SIZE_DEF + j] * z_shadow[j];
			// The arithmetic shift rounds toward minus infinity.
			w_wide = (mz_sum >>> 16) + q_shadow[i];
			if (w_wide > VAL_MAX)
				w_i = VAL_MAX;
			else if (w_wide < VAL_MIN)
				w_i = VAL_MIN;
			else
				w_i = w_wide[63:0];
			z_i = z_shadow[i];
			q_i = q_shadow[i];
			if (z_i < 0) begin
				mag = -z_i;
				err = sat_add(err, mag << 16);
			end
			if (w_i < 0) begin
				mag = -w_i;
				err = sat_add(err, mag << 16);
			end
			if ((z_i < 0 && w_i < 0) || (z_i > 0 && w_i > 0)) begin
				zw = z_i * w_i;
				err = sat_add(err, zw);
			end
			q_sq = q_i * q_i;
			q_sq_sum = q_sq_sum + q_sq;
		end
		lhs = err;
		lhs = (lhs * lhs) << 16;
		tol_sq = tol_shadow;
		tol_sq = tol_sq * tol_sq;
		rhs = tol_sq * q_sq_sum;
		v.failed = (lhs > rhs);
		v.error_sum = err;
		return v;
	endfunction

	task automatic flag_mismatch(string what, logic [ERR_W-1:0] want_v, logic [ERR_W-1:0] got_v);
		bad_count++;
		if (bad_count <= REPORT_LIMIT)
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			size_shadow = SIZE_RESET;
			tol_shadow = TOL_RESET;
			awaited_verdicts.delete();
			bad_count = 0;
			pending <= 0;
			mismatch_count <= 0;
		end else begin
			// Results first, so that an evaluate taken in the same cycle queues behind.
			if (done) begin
				if (awaited_verdicts.size() == 0) begin
					bad_count++;
					if (bad_count <= REPORT_LIMIT)
						$display("%0t: result with none expected: failed %0d, error_sum %h",
							$time, failed, error_sum);
				end else begin
					want = awaited_verdicts.pop_front();
					if (failed !== want.failed)
						flag_mismatch("failed", want.failed, failed);
					if (error_sum !== want.error_sum)
						flag_mismatch("error_sum", want.error_sum, error_sum);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SIZE)
					size_shadow = cfg_data[SIZE_W-1:0];
				else if (cfg_index == CFG_TOL)
					tol_shadow = cfg_data[TOL_W-1:0];
			end
			if (start && !busy) begin
				case (operation)
					OP_LOAD_M: m_shadow[row*MAX_SIZE_DEF + column] = value;
					OP_LOAD_Q: q_shadow[row] = value;
					OP_LOAD_Z: z_shadow[row] = value;
					OP_EVAL:   awaited_verdicts.push_back(residual_verdict());
				endcase
			end
			pending <= awaited_verdicts.size();
			mismatch_count <= bad_count;
		end
	end

endmodule

### verif/tb_lcp_residual_check.sv
// Testbench top of the complementarity residual checker: clock, reset, stimulus and verdict.
module tb_lcp_residual_check;
	timeunit 1ns;
	timeprecision 1ps;
	import lcp_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 5;
	// Stimulus stops drawing new random problems once this many items went in.
	localparam int ITEM_TARGET    = 1550;
	// Cycles to let pass after the last result before a register write or the end.
	localparam int SETTLE_CYCLES  = 40;
	// Covers a full-size evaluate plus the longest sender gap.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic signed [VAL_W-1:0] ONE = 32'sh0001_0000;

	// Kinds of content used to fill a problem.
	typedef enum {
		FILL_SOLVABLE,
		FILL_SMALL,
		FILL_WIDE,
		FILL_EDGE
	} fill_t;

	typedef struct {
		op_t               op;
		logic [5:0]        r;
		logic [5:0]        c;
		logic [VAL_W-1:0]  v;
	} load_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	op_t                     operation = OP_LOAD_M;
	logic [5:0]              row = '0;
	logic [5:0]              column = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    done;
	logic                    failed;
	logic [ERR_W-1:0]        error_sum;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic                    cfg_index = CFG_SIZE;
	logic [CFG_W-1:0]        cfg_data = '0;

	int                      mismatch_count;
	int                      pending;
	int                      items_sent = 0;
	int                      idle_cycles = 0;
	// When set, the sender streams items back to back with no gaps.
	logic                    burst = 1'b0;
	// Dimension last written to the size register, so an unchanged size is not written again.
	logic [SIZE_W-1:0]       cur_size = SIZE_RESET;

	always #(CLK_PERIOD/2) clk = ~clk;

	lcp_residual_check i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.row       (row),
		.column    (column),
		.value     (value),
		.done      (done),
		.failed    (failed),
		.error_sum (error_sum),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lcp_residual_check_monitor i_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.row            (row),
		.column         (column),
		.value          (value),
		.done           (done),
		.failed         (failed),
		.error_sum      (error_sum),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	// The watchdog restarts whenever anything crosses a channel. A full-size
	// evaluate is the longest quiet stretch a correct block can show.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Sender gaps: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [5:0] rand_index();
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic op_t pick_load_op();
		case ($urandom_range(0, 2))
			0:       return OP_LOAD_M;
			1:       return OP_LOAD_Q;
			default: return OP_LOAD_Z;
		endcase
	endfunction

	// Small values stay within plus or minus 4.0 in Q16.16; edge values hit the
	// ends of the signed range and the unit steps around zero.
	function automatic logic [VAL_W-1:0] pick_value(fill_t style);
		case (style)
			FILL_SMALL: return $urandom_range(0, 1 << 19) - (1 << 18);
			FILL_WIDE:  return $urandom();
			FILL_EDGE: begin
				case ($urandom_range(0, 7))
					0:       return VAL_MAX;
					1:       return VAL_MIN;
					2:       return '0;
					3:       return 32'd1;
					4:       return '1;
					5:       return ONE;
					6:       return -ONE;
					default: return $urandom();
				endcase
			end
			default: return '0;
		endcase
	endfunction

	function automatic logic [TOL_W-1:0] pick_tolerance();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			2:       return TOL_RESET;
			3:       return $urandom_range(0, 1 << 20);
			default: return $urandom();
		endcase
	endfunction

	function automatic load_t make_load(op_t op, logic [5:0] r, logic [5:0] c,
			logic [VAL_W-1:0] v);
		load_t ld;
		ld.op = op;
		ld.r = r;
		ld.c = c;
		ld.v = v;
		return ld;
	endfunction

	// Presents one item and holds it until the block takes it. With no gap
	// following, start simply stays high for the next item.
	task automatic push_item(op_t op, logic [5:0] r, logic [5:0] c, logic [VAL_W-1:0] v);
		int gap;
		start <= 1'b1;
		operation <= op;
		row <= r;
		column <= c;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic evaluate();
		push_item(OP_EVAL, rand_index(), rand_index(), $urandom());
	endtask

	// Stops sending and waits until every expected result has come back, then a
	// little longer so that the last loads have surely landed.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Valid drops for one cycle after each write so that back-to-back writes
	// never put two assignments on it in the same step.
	task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_SIZE)
			cur_size = data[SIZE_W-1:0];
		@(posedge clk);
	endtask

	// Directed cases: empty dimension, saturation of w in both directions, an
	// all-zero q with and without error, and a saturated error sum.
	task automatic run_directed();
		settle();
		write_reg(CFG_SIZE, 0);
		write_reg(CFG_TOL, '0);
		evaluate();

		settle();
		write_reg(CFG_SIZE, 1);
		// M z is about +2^46, far above the Q16.16 range, while z is negative.
		push_item(OP_LOAD_M, 6'd0, 6'd0, VAL_MIN);
		push_item(OP_LOAD_Q, 6'd0, rand_index(), VAL_MAX);
		push_item(OP_LOAD_Z, 6'd0, rand_index(), VAL_MIN);
		evaluate();
		// All-zero q with a perfect solution: no error, and the test must not fail.
		push_item(OP_LOAD_Q, 6'd0, rand_index(), '0);
		push_item(OP_LOAD_Z, 6'd0, rand_index(), '0);
		evaluate();
		// All-zero q with a negative z: any error at all counts as a failure.
		push_item(OP_LOAD_Z, 6'd0, rand_index(), -ONE);
		evaluate();

		// Four indices of the largest products drive the error sum into saturation,
		// and w saturates toward the negative end.
		settle();
		write_reg(CFG_SIZE, 4);
		write_reg(CFG_TOL, '1);
		for (int i = 0; i < 4; i++) begin
			push_item(OP_LOAD_Q, 6'(i), rand_index(), VAL_MIN);
			push_item(OP_LOAD_Z, 6'(i), rand_index(), VAL_MIN);
			for (int j = 0; j < 4; j++)
				push_item(OP_LOAD_M, 6'(i), 6'(j), VAL_MAX);
		end
		evaluate();
	endtask

	// One random problem: every entry the evaluate reads is loaded first, in a
	// shuffled order and sometimes with stray loads mixed in, then evaluated. Up
	// to two follow-up rounds change single entries and evaluate again without
	// waiting, so loads queue up behind a running evaluate.
	task automatic run_problem();
		int                      n;
		int                      k;
		int                      pick;
		logic                    new_tol;
		fill_t                   style;
		fill_t                   refill;
		logic signed [VAL_W-1:0] qv [MAX_SIZE_DEF];
		logic signed [VAL_W-1:0] zv [MAX_SIZE_DEF];
		load_t                   plan[$];
		load_t                   tmp;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			n = 0;
		else if (pick < 70)
			n = $urandom_range(1, 4);
		else if (pick < 92)
			n = $urandom_range(5, 8);
		else
			n = $urandom_range(9, 12);
		new_tol = ($urandom_range(0, 2) == 0);
		burst = ($urandom_range(0, 3) == 0);
		// Registers change only while the block is idle.
		if (n != cur_size || new_tol) begin
			settle();
			if (n != cur_size)
				write_reg(CFG_SIZE, n);
			if (new_tol)
				write_reg(CFG_TOL, pick_tolerance());
		end

		pick = $urandom_range(0, 9);
		if (pick < 3)
			style = FILL_SOLVABLE;
		else if (pick < 6)
			style = FILL_SMALL;
		else if (pick < 8)
			style = FILL_EDGE;
		else
			style = FILL_WIDE;
		refill = (style == FILL_SOLVABLE) ? FILL_SMALL : style;

		// A solvable problem uses M = I and z = max(0, -q), so w = max(q, 0) and
		// the error is exactly zero; sometimes one z is nudged to make it small.
		for (int i = 0; i < n; i++) begin
			if (style == FILL_SOLVABLE) begin
				qv[i] = pick_value(FILL_SMALL);
				zv[i] = (qv[i] < 0) ? -qv[i] : '0;
			end else begin
				qv[i] = pick_value(style);
				zv[i] = pick_value(style);
			end
		end
		if (style == FILL_SOLVABLE && n > 0 && $urandom_range(0, 1) == 1) begin
			k = $urandom_range(0, n - 1);
			zv[k] = zv[k] + $urandom_range(0, 511) - 256;
		end

		for (int i = 0; i < n; i++) begin
			plan.push_back(make_load(OP_LOAD_Q, 6'(i), rand_index(), qv[i]));
			plan.push_back(make_load(OP_LOAD_Z, 6'(i), rand_index(), zv[i]));
			for (int j = 0; j < n; j++) begin
				if (style == FILL_SOLVABLE)
					plan.push_back(make_load(OP_LOAD_M, 6'(i), 6'(j), (i == j) ? ONE : '0));
				else
					plan.push_back(make_load(OP_LOAD_M, 6'(i), 6'(j), pick_value(style)));
			end
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				plan.push_back(make_load(pick_load_op(), rand_index(), rand_index(), $urandom()));
		for (int i = plan.size() - 1; i > 0; i--) begin
			k = $urandom_range(0, i);
			tmp = plan[i];
			plan[i] = plan[k];
			plan[k] = tmp;
		end
		foreach (plan[i])
			push_item(plan[i].op, plan[i].r, plan[i].c, plan[i].v);
		evaluate();

		repeat ($urandom_range(0, 2)) begin
			if (n > 0)
				repeat ($urandom_range(1, 4))
					push_item(pick_load_op(), 6'($urandom_range(0, n - 1)),
						6'($urandom_range(0, n - 1)), pick_value(refill));
			evaluate();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		while (items_sent < ITEM_TARGET)
			run_problem();

		// Every result is in once nothing is pending; settle adds the tail.
		settle();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
